// File: rtl/lghmc_pkg.sv
package lghmc_pkg;

   // Defaults for the top-level parameters.
   localparam int MAX_DIM_LOG2_DEF = 7;
   localparam int MAX_ADATOMS_DEF  = 4096;
   localparam int RANDOM_BITS_DEF  = 16;

   // Fixed field widths of the item formats.
   localparam int ATOM_INDEX_W = 12;
   localparam int SITE_FIELD_W = 14;
   localparam int DIR_W        = 3;
   localparam int COUNT_W      = 3;
   localparam int STATUS_W     = 3;

   // Request item layout: op travels in tuser, the rest packed in tdata.
   localparam int REQ_ATOM_LSB  = 0;
   localparam int REQ_SITE_LSB  = REQ_ATOM_LSB + ATOM_INDEX_W;
   localparam int REQ_DIR_LSB   = REQ_SITE_LSB + SITE_FIELD_W;
   localparam int REQ_RND_LSB   = REQ_DIR_LSB + DIR_W;
   localparam int REQ_FIXED_W   = REQ_RND_LSB;

   // Result item layout: status travels in tuser, the rest packed in tdata.
   localparam int RSP_FIELDS_W  = SITE_FIELD_W + 2 * COUNT_W;
   localparam int RSP_DATA_W    = ((RSP_FIELDS_W + 7) / 8) * 8;
   localparam int RSP_PAD_W     = RSP_DATA_W - RSP_FIELDS_W;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 13;
   localparam int LG_REG_W    = 3;
   localparam int COUNT_REG_W = 13;
   localparam int MODE_REG_W  = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_LATTICE_DIM_LOG2 = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ADATOM_COUNT     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERACTION_MODE = 2'd2;

   localparam logic [LG_REG_W-1:0]    LG_RESET    = 3'd7;
   localparam logic [COUNT_REG_W-1:0] COUNT_RESET = 13'd1;
   localparam logic [MODE_REG_W-1:0]  MODE_RESET  = 2'd0;
   localparam logic [MODE_REG_W-1:0]  MODE_FREE   = 2'd0;

   // Operation codes.
   localparam logic OP_PLACE = 1'b0;
   localparam logic OP_HOP   = 1'b1;

   // Hop directions.
   localparam logic [DIR_W-1:0] DIR_PLUS_ONE  = 3'd0;
   localparam logic [DIR_W-1:0] DIR_MINUS_ONE = 3'd1;
   localparam logic [DIR_W-1:0] DIR_PLUS_ROW  = 3'd2;
   localparam logic [DIR_W-1:0] DIR_MINUS_ROW = 3'd3;
   localparam logic [DIR_W-1:0] DIR_PLUS_DIAG = 3'd4;
   localparam logic [DIR_W-1:0] DIR_COUNT     = 3'd6;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_PLACED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_MOVED    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_BLOCKED  = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_INVALID  = 3'd4;

   // Neighbor sweep: six around the old site, then six around the target.
   localparam logic [3:0] SWEEP_SPLIT = 4'd6;
   localparam logic [3:0] SWEEP_END   = 4'd12;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_ATOM_RD,
      ST_ATOM_CHK,
      ST_PLACE_CHK,
      ST_PLACE_CLR,
      ST_PLACE_SET,
      ST_HOP_CHK,
      ST_COUNT,
      ST_DECIDE,
      ST_MOVE_CLR,
      ST_MOVE_SET,
      ST_FINISH
   } state_type;

endpackage

// File: rtl/lghmc_ram.sv
module lghmc_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AddrW-1:0] waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AddrW-1:0] raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/lattice_gas_hop_monte_carlo.sv
// Lattice-gas hop engine: a Metropolis-style hop trial for adatoms on a
// square lattice with six (hexagonal) neighbors per site and helical wrap.
// Request items arrive on the req_ stream: tuser carries the operation
// (place or hop), tdata the atom index, target site, direction and random
// fraction. Every request gives exactly one result item on the rsp_ stream:
// tuser carries the status, tdata the atom's site and the two neighbor counts.
// Configuration registers are written through the csr_ port; the user must
// write them only while idle, as the block itself does not enforce this.
// The block works on one item at a time and takes the next item only after
// returning to idle. The single read port of the occupancy memory paces a
// hop: it reads the target and then twelve neighbor bits, one per cycle, and
// the move itself takes two writes through the single write port.
// After reset a clearing pass writes every occupancy bit and every adatom
// entry to zero, one address per cycle, over the larger of the two memories.
// req_tready stays low during the pass. If the receiver stalls, a finished
// result waits in the output register and the block holds the next item's
// result until it drains; a new request is still accepted while a result
// waits.
module lattice_gas_hop_monte_carlo #(
   parameter int MAX_DIM_LOG2 = lghmc_pkg::MAX_DIM_LOG2_DEF,
   parameter int MAX_ADATOMS  = lghmc_pkg::MAX_ADATOMS_DEF,
   parameter int RANDOM_BITS  = lghmc_pkg::RANDOM_BITS_DEF
) (
   input  logic clock,
   input  logic reset,

   // Request stream.
   input  logic req_tvalid,
   output logic req_tready,
   // tdata from bit 0: atom_index, site, direction, random_fraction, zero fill.
   input  logic [((lghmc_pkg::REQ_FIXED_W + RANDOM_BITS + 7) / 8) * 8 - 1:0] req_tdata,
   // tuser: op.
   input  logic req_tuser,

   // Result stream.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // tdata from bit 0: atom_site, neighbors_before, neighbors_after, zero fill.
   output logic [lghmc_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tuser: status.
   output logic [lghmc_pkg::STATUS_W-1:0] rsp_tuser,

   // Configuration write port.
   input  logic                             csr_we,
   input  logic [lghmc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lghmc_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   import lghmc_pkg::*;

   localparam int SiteW    = 2 * MAX_DIM_LOG2;
   localparam int OccDepth = 1 << SiteW;
   localparam int AtomW    = (MAX_ADATOMS > 1) ? $clog2(MAX_ADATOMS) : 1;
   localparam int ClearN   = (OccDepth > MAX_ADATOMS) ? OccDepth : MAX_ADATOMS;
   localparam int ClrW     = $clog2(ClearN);
   localparam int LgW      = $clog2(MAX_DIM_LOG2 + 1);
   localparam int ProdW    = RANDOM_BITS + 3;
   localparam int ThrW     = RANDOM_BITS + 4;

   // Configuration registers.
   logic [LG_REG_W-1:0]    lg_ff;
   logic [COUNT_REG_W-1:0] count_ff;
   logic [MODE_REG_W-1:0]  mode_ff;

   // Sequencer.
   state_type       state_ff, state_in;
   logic [ClrW-1:0] clr_cnt_ff, clr_cnt_in;

   // Item being worked on.
   logic                    op_ff;
   logic [ATOM_INDEX_W-1:0] atom_ff, atom_in;
   logic [SiteW-1:0]        site_ff, site_in;
   logic [DIR_W-1:0]        dir_ff, dir_in;
   logic [RANDOM_BITS-1:0]  rnd_ff, rnd_in;
   logic                    op_in;
   logic [SiteW-1:0]        old_ff, old_in;
   logic [SiteW-1:0]        tgt_ff, tgt_in;
   logic                    placed_ff, placed_in;
   logic [STATUS_W-1:0]     status_ff, status_in;
   logic [SiteW-1:0]        where_ff, where_in;
   logic [COUNT_W-1:0]      before_ff, before_in;
   logic [COUNT_W-1:0]      after_ff, after_in;
   logic [3:0]              sweep_ff, sweep_in;
   logic                    acc_vld_ff, acc_vld_in;
   logic                    acc_old_ff, acc_old_in;

   // Result register.
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]     rsp_status_ff, rsp_status_in;
   logic [SITE_FIELD_W-1:0] rsp_site_ff, rsp_site_in;
   logic [COUNT_W-1:0]      rsp_before_ff, rsp_before_in;
   logic [COUNT_W-1:0]      rsp_after_ff, rsp_after_in;

   // Memory ports.
   logic             occ_we;
   logic [SiteW-1:0] occ_waddr;
   logic             occ_wdata;
   logic [SiteW-1:0] occ_raddr;
   logic             occ_rdata;
   logic             atom_we;
   logic [AtomW-1:0] atom_waddr;
   logic [SiteW:0]   atom_wdata;
   logic [AtomW-1:0] atom_addr;
   logic [SiteW:0]   atom_rdata;

   // Decoded request.
   logic                    req_acc;
   logic [ATOM_INDEX_W-1:0] in_atom;
   logic [SITE_FIELD_W-1:0] in_site;
   logic [DIR_W-1:0]        in_dir;
   logic [RANDOM_BITS-1:0]  in_rnd;
   logic                    atom_ok;
   logic                    site_ok;
   logic                    in_valid;
   logic                    rsp_free;

   // Lattice geometry.
   logic [LgW-1:0]   lg_eff;
   logic [31:0]      nsites;
   logic [SiteW-1:0] dim;
   logic [SiteW-1:0] site_mask;

   // Shared neighbor adder.
   logic [SiteW-1:0] nb_center;
   logic [DIR_W-1:0] nb_dir;
   logic [SiteW-1:0] nb_offset;
   logic [SiteW-1:0] nb_site;
   logic [DIR_W-1:0] sweep_dir;

   // Acceptance test.
   logic [COUNT_W-1:0] after_adj;
   logic [3:0]         energy_k;
   logic [ProdW-1:0]   rnd_x6;
   logic [ThrW-1:0]    threshold;
   logic               hop_accept;

   assign req_acc = req_tvalid && req_tready;
   assign in_atom = req_tdata[REQ_ATOM_LSB +: ATOM_INDEX_W];
   assign in_site = req_tdata[REQ_SITE_LSB +: SITE_FIELD_W];
   assign in_dir  = req_tdata[REQ_DIR_LSB +: DIR_W];
   assign in_rnd  = req_tdata[REQ_RND_LSB +: RANDOM_BITS];

   // The edge log2 is clamped to the range the memory supports.
   always_comb begin
      if (lg_ff == '0) begin
         lg_eff = LgW'(1);
      end else if (32'(lg_ff) > 32'(MAX_DIM_LOG2)) begin
         lg_eff = LgW'(MAX_DIM_LOG2);
      end else begin
         lg_eff = LgW'(lg_ff);
      end
   end

   assign nsites    = 32'(1) << {lg_eff, 1'b0};
   assign dim       = SiteW'(1) << lg_eff;
   // At the largest lattice the shift wraps to zero and the mask is all ones.
   assign site_mask = (SiteW'(1) << {lg_eff, 1'b0}) - SiteW'(1);

   assign atom_ok  = (32'(in_atom) < 32'(count_ff)) && (32'(in_atom) < 32'(MAX_ADATOMS));
   assign site_ok  = 32'(in_site) < nsites;
   assign in_valid = atom_ok && ((req_tuser == OP_PLACE) ? site_ok : (in_dir < DIR_COUNT));
   assign rsp_free = !rsp_valid_ff || rsp_tready;

   assign atom_addr = AtomW'(32'(atom_ff));

   // One adder serves both the hop target and the twelve neighbor reads.
   assign sweep_dir = (sweep_ff < SWEEP_SPLIT) ? sweep_ff[DIR_W-1:0]
                                               : DIR_W'(sweep_ff - SWEEP_SPLIT);
   assign nb_center = (state_ff == ST_ATOM_CHK) ? atom_rdata[SiteW-1:0]
                    : ((sweep_ff < SWEEP_SPLIT) ? old_ff : tgt_ff);
   assign nb_dir    = (state_ff == ST_ATOM_CHK) ? dir_ff : sweep_dir;

   always_comb begin
      case (nb_dir)
         DIR_PLUS_ONE:  nb_offset = SiteW'(1);
         DIR_MINUS_ONE: nb_offset = '1;
         DIR_PLUS_ROW:  nb_offset = dim;
         DIR_MINUS_ROW: nb_offset = SiteW'(0) - dim;
         DIR_PLUS_DIAG: nb_offset = dim - SiteW'(1);
         default:       nb_offset = SiteW'(1) - dim;
      endcase
   end

   assign nb_site = (nb_center + nb_offset) & site_mask;

   // The vacated old site is one of the target's neighbors, so it is taken off.
   assign after_adj  = (after_ff == '0) ? '0 : after_ff - COUNT_W'(1);
   assign energy_k   = 4'd5 + 4'(before_ff) - 4'(after_adj);
   assign rnd_x6     = ProdW'({rnd_ff, 2'b00}) + ProdW'({rnd_ff, 1'b0});
   assign threshold  = {energy_k, {RANDOM_BITS{1'b0}}};
   assign hop_accept = (mode_ff == MODE_FREE) || (after_adj <= before_ff)
                    || ({1'b0, rnd_x6} < threshold);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == ClrW'(ClearN - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_acc) begin
               state_in = in_valid ? ST_ATOM_RD : ST_FINISH;
            end
         end
         ST_ATOM_RD: begin
            state_in = ST_ATOM_CHK;
         end
         ST_ATOM_CHK: begin
            if (op_ff == OP_PLACE) begin
               state_in = ST_PLACE_CHK;
            end else if (atom_rdata[SiteW]) begin
               state_in = ST_HOP_CHK;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_PLACE_CHK: begin
            if (occ_rdata) begin
               state_in = ST_FINISH;
            end else if (placed_ff) begin
               state_in = ST_PLACE_CLR;
            end else begin
               state_in = ST_PLACE_SET;
            end
         end
         ST_PLACE_CLR: begin
            state_in = ST_PLACE_SET;
         end
         ST_PLACE_SET: begin
            state_in = ST_FINISH;
         end
         ST_HOP_CHK: begin
            state_in = occ_rdata ? ST_FINISH : ST_COUNT;
         end
         ST_COUNT: begin
            if (sweep_ff == SWEEP_END) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = hop_accept ? ST_MOVE_CLR : ST_FINISH;
         end
         ST_MOVE_CLR: begin
            state_in = ST_MOVE_SET;
         end
         ST_MOVE_SET: begin
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      clr_cnt_in    = clr_cnt_ff;
      op_in         = op_ff;
      atom_in       = atom_ff;
      site_in       = site_ff;
      dir_in        = dir_ff;
      rnd_in        = rnd_ff;
      old_in        = old_ff;
      tgt_in        = tgt_ff;
      placed_in     = placed_ff;
      status_in     = status_ff;
      where_in      = where_ff;
      before_in     = before_ff;
      after_in      = after_ff;
      sweep_in      = sweep_ff;
      acc_vld_in    = 1'b0;
      acc_old_in    = acc_old_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_site_in   = rsp_site_ff;
      rsp_before_in = rsp_before_ff;
      rsp_after_in  = rsp_after_ff;
      occ_we        = 1'b0;
      occ_waddr     = old_ff;
      occ_wdata     = 1'b0;
      occ_raddr     = nb_site;
      atom_we       = 1'b0;
      atom_waddr    = atom_addr;
      atom_wdata    = {1'b1, site_ff};
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + ClrW'(1);
            occ_we     = 32'(clr_cnt_ff) < 32'(OccDepth);
            occ_waddr  = clr_cnt_ff[SiteW-1:0];
            atom_we    = 32'(clr_cnt_ff) < 32'(MAX_ADATOMS);
            atom_waddr = clr_cnt_ff[AtomW-1:0];
            atom_wdata = '0;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_acc) begin
               op_in     = req_tuser;
               atom_in   = in_atom;
               site_in   = SiteW'(32'(in_site));
               dir_in    = in_dir;
               rnd_in    = in_rnd;
               status_in = STATUS_INVALID;
               where_in  = '0;
               before_in = '0;
               after_in  = '0;
            end
         end
         ST_ATOM_RD: begin
         end
         ST_ATOM_CHK: begin
            old_in    = atom_rdata[SiteW-1:0];
            placed_in = atom_rdata[SiteW];
            tgt_in    = nb_site;
            if (op_ff == OP_PLACE) begin
               occ_raddr = site_ff;
            end
         end
         ST_PLACE_CHK: begin
            if (occ_rdata) begin
               status_in = STATUS_BLOCKED;
               where_in  = placed_ff ? old_ff : '0;
            end
         end
         ST_PLACE_CLR: begin
            occ_we = 1'b1;
         end
         ST_PLACE_SET: begin
            occ_we    = 1'b1;
            occ_waddr = site_ff;
            occ_wdata = 1'b1;
            atom_we   = 1'b1;
            status_in = STATUS_PLACED;
            where_in  = site_ff;
         end
         ST_HOP_CHK: begin
            sweep_in = '0;
            if (occ_rdata) begin
               status_in = STATUS_BLOCKED;
               where_in  = old_ff;
            end
         end
         ST_COUNT: begin
            // One neighbor read issued per cycle; its bit is counted in the next cycle.
            if (sweep_ff != SWEEP_END) begin
               sweep_in   = sweep_ff + 4'd1;
               acc_vld_in = 1'b1;
               acc_old_in = sweep_ff < SWEEP_SPLIT;
            end
            if (acc_vld_ff) begin
               if (acc_old_ff) begin
                  before_in = before_ff + COUNT_W'(occ_rdata);
               end else begin
                  after_in = after_ff + COUNT_W'(occ_rdata);
               end
            end
         end
         ST_DECIDE: begin
            after_in = after_adj;
            if (!hop_accept) begin
               status_in = STATUS_REJECTED;
               where_in  = old_ff;
            end
         end
         ST_MOVE_CLR: begin
            occ_we = 1'b1;
         end
         ST_MOVE_SET: begin
            occ_we     = 1'b1;
            occ_waddr  = tgt_ff;
            occ_wdata  = 1'b1;
            atom_we    = 1'b1;
            atom_wdata = {1'b1, tgt_ff};
            status_in  = STATUS_MOVED;
            where_in   = tgt_ff;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_site_in   = SITE_FIELD_W'(32'(where_ff));
               rsp_before_in = before_ff;
               rsp_after_in  = after_ff;
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_cnt_ff   <= '0;
         acc_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lg_ff        <= LG_RESET;
         count_ff     <= COUNT_RESET;
         mode_ff      <= MODE_RESET;
      end else begin
         state_ff     <= state_in;
         clr_cnt_ff   <= clr_cnt_in;
         acc_vld_ff   <= acc_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_LATTICE_DIM_LOG2: lg_ff    <= csr_wdata[LG_REG_W-1:0];
               CSR_ADATOM_COUNT:     count_ff <= csr_wdata[COUNT_REG_W-1:0];
               CSR_INTERACTION_MODE: mode_ff  <= csr_wdata[MODE_REG_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      atom_ff       <= atom_in;
      site_ff       <= site_in;
      dir_ff        <= dir_in;
      rnd_ff        <= rnd_in;
      old_ff        <= old_in;
      tgt_ff        <= tgt_in;
      placed_ff     <= placed_in;
      status_ff     <= status_in;
      where_ff      <= where_in;
      before_ff     <= before_in;
      after_ff      <= after_in;
      sweep_ff      <= sweep_in;
      acc_old_ff    <= acc_old_in;
      rsp_status_ff <= rsp_status_in;
      rsp_site_ff   <= rsp_site_in;
      rsp_before_ff <= rsp_before_in;
      rsp_after_ff  <= rsp_after_in;
   end

   // Occupancy bitmap, one bit per site.
   lghmc_ram #(
      .WIDTH (1),
      .DEPTH (OccDepth)
   ) u_occ_ram (
      .clock (clock),
      .we    (occ_we),
      .waddr (occ_waddr),
      .wdata (occ_wdata),
      .raddr (occ_raddr),
      .rdata (occ_rdata)
   );

   // Adatom table: placed flag above the site.
   lghmc_ram #(
      .WIDTH (SiteW + 1),
      .DEPTH (MAX_ADATOMS)
   ) u_atom_ram (
      .clock (clock),
      .we    (atom_we),
      .waddr (atom_waddr),
      .wdata (atom_wdata),
      .raddr (atom_addr),
      .rdata (atom_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_after_ff, rsp_before_ff, rsp_site_ff};

   // An accepted item always leaves the idle state on the next cycle.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // A new result only appears out of the finishing state.
   a_result_from_finish: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !$past(rsp_valid_ff)) |-> $past(state_ff == ST_FINISH))
      else $error("result raised outside the finishing state");

   // The adatom table is only written by the clearing pass or a completed place/move.
   a_atom_write_states: assert property (@(posedge clock) disable iff (reset)
      atom_we |-> (state_ff == ST_CLEAR || state_ff == ST_PLACE_SET
                   || state_ff == ST_MOVE_SET))
      else $error("adatom table written out of sequence");

   // Neighbor counts never pass six.
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DECIDE) |-> (before_ff <= COUNT_W'(6) && after_ff <= COUNT_W'(6)))
      else $error("neighbor count out of range");

   // A hop result with a nonzero count must be a move or an energy rejection.
   a_counts_only_on_trial: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_before_ff != '0 || rsp_after_ff != '0))
         |-> (rsp_status_ff == STATUS_MOVED || rsp_status_ff == STATUS_REJECTED))
      else $error("neighbor counts reported on a non-trial result");

endmodule

// File: tb/hop_result_checker.sv
module hop_result_checker
   import lghmc_pkg::*;
(
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [((REQ_FIXED_W + RANDOM_BITS_DEF + 7) / 8) * 8 - 1:0] req_tdata,
   input  logic                             req_tuser,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic [RSP_DATA_W-1:0]            rsp_tdata,
   input  logic [STATUS_W-1:0]              rsp_tuser,
   input  logic                             csr_we,
   input  logic [CSR_INDEX_W-1:0]           csr_index,
   input  logic [CSR_DATA_W-1:0]            csr_wdata,
   output int unsigned                      pending_results,
   output int unsigned                      fail_count
);

   localparam int SITE_COUNT = 1 << (2 * MAX_DIM_LOG2_DEF);
   localparam int ENERGY_BASE = 5;
   localparam int ENERGY_DEN = 6;

   typedef struct packed {
      logic [STATUS_W-1:0]     status;
      logic [SITE_FIELD_W-1:0] atom_site;
      logic [COUNT_W-1:0]      near_old;
      logic [COUNT_W-1:0]      near_new;
   } hop_outcome_type;

   bit                      occupied [SITE_COUNT];
   logic [SITE_FIELD_W-1:0] home_site [MAX_ADATOMS_DEF];
   bit                      is_placed [MAX_ADATOMS_DEF];
   logic [LG_REG_W-1:0]     dim_lg;
   logic [COUNT_REG_W-1:0]  atom_limit;
   logic [MODE_REG_W-1:0]   energy_mode;
   hop_outcome_type         awaited_outcomes [$];
   int unsigned             result_seq;

   function automatic int unsigned step_site(int unsigned c, logic [DIR_W-1:0] dir,
                                             int unsigned dim, int unsigned mask);
      int unsigned t;
      case (dir)
         DIR_PLUS_ONE:  t = c + 1;
         DIR_MINUS_ONE: t = c - 1;
         DIR_PLUS_ROW:  t = c + dim;
         DIR_MINUS_ROW: t = c - dim;
         DIR_PLUS_DIAG: t = c + (dim - 1);
         default:       t = c - (dim - 1);
      endcase
      return t & mask;
   endfunction

   function automatic int unsigned count_neighbors(int unsigned c, int unsigned dim,
                                                   int unsigned mask);
      int unsigned n;
      n = 0;
      for (int j = 0; j < DIR_COUNT; j++) begin
         if (occupied[step_site(c, DIR_W'(j), dim, mask)]) n++;
      end
      return n;
   endfunction

   // Applies one request to the shadow lattice and returns the result it must give.
   task automatic predict_outcome(input logic op, input logic [ATOM_INDEX_W-1:0] atom,
                                  input logic [SITE_FIELD_W-1:0] site,
                                  input logic [DIR_W-1:0] dir,
                                  input logic [RANDOM_BITS_DEF-1:0] frac,
                                  output hop_outcome_type res);
      int unsigned lg, dim, nsites, mask, origin, dest, cnt, k;
      bit          accept;
      lg = dim_lg;
      if (lg < 1) lg = 1;
      if (lg > MAX_DIM_LOG2_DEF) lg = MAX_DIM_LOG2_DEF;
      dim = 1 << lg;
      nsites = 1 << (2 * lg);
      mask = nsites - 1;
      res = '0;
      res.status = STATUS_INVALID;
      if (atom < atom_limit && atom < MAX_ADATOMS_DEF) begin
         if (op == OP_PLACE) begin
            if (site < nsites) begin
               if (occupied[site]) begin
                  res.status = STATUS_BLOCKED;
                  res.atom_site = is_placed[atom] ? home_site[atom] : '0;
               end else begin
                  if (is_placed[atom]) occupied[home_site[atom]] = 1'b0;
                  occupied[site] = 1'b1;
                  home_site[atom] = site;
                  is_placed[atom] = 1'b1;
                  res.status = STATUS_PLACED;
                  res.atom_site = site;
               end
            end
         end else if (is_placed[atom] && dir < DIR_COUNT) begin
            origin = home_site[atom];
            dest = step_site(origin, dir, dim, mask);
            res.atom_site = SITE_FIELD_W'(origin);
            if (occupied[dest]) begin
               res.status = STATUS_BLOCKED;
            end else begin
               res.near_old = COUNT_W'(count_neighbors(origin, dim, mask));
               cnt = count_neighbors(dest, dim, mask);
               res.near_new = COUNT_W'(cnt != 0 ? cnt - 1 : 0);
               if (energy_mode == MODE_FREE || res.near_new <= res.near_old) begin
                  accept = 1'b1;
               end else begin
                  // Exact form of frac / 2^bits < (5 + old - new) / 6.
                  k = ENERGY_BASE + res.near_old - res.near_new;
                  accept = (ENERGY_DEN * int'(frac)) < (k << RANDOM_BITS_DEF);
               end
               if (accept) begin
                  occupied[origin] = 1'b0;
                  occupied[dest] = 1'b1;
                  home_site[atom] = SITE_FIELD_W'(dest);
                  res.atom_site = SITE_FIELD_W'(dest);
                  res.status = STATUS_MOVED;
               end else begin
                  res.status = STATUS_REJECTED;
               end
            end
         end
      end
   endtask

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      fail_count++;
      $display("mismatch at result %0d: %s got %0d, predicted %0d",
               result_seq, what, got, want);
   endtask

   always @(posedge clock) begin
      hop_outcome_type want, got;
      if (reset) begin
         foreach (occupied[i]) occupied[i] = 1'b0;
         foreach (is_placed[i]) is_placed[i] = 1'b0;
         foreach (home_site[i]) home_site[i] = '0;
         dim_lg = LG_RESET;
         atom_limit = COUNT_RESET;
         energy_mode = MODE_RESET;
         awaited_outcomes.delete();
         result_seq = 0;
         fail_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               CSR_LATTICE_DIM_LOG2: dim_lg = csr_wdata[LG_REG_W-1:0];
               CSR_ADATOM_COUNT:     atom_limit = csr_wdata[COUNT_REG_W-1:0];
               CSR_INTERACTION_MODE: energy_mode = csr_wdata[MODE_REG_W-1:0];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            got.status = rsp_tuser;
            got.atom_site = rsp_tdata[0 +: SITE_FIELD_W];
            got.near_old = rsp_tdata[SITE_FIELD_W +: COUNT_W];
            got.near_new = rsp_tdata[SITE_FIELD_W + COUNT_W +: COUNT_W];
            if (awaited_outcomes.size() == 0) begin
               flag_mismatch("status of an unrequested result", got.status, 0);
            end else begin
               want = awaited_outcomes.pop_front();
               if (got.status !== want.status)
                  flag_mismatch("status", got.status, want.status);
               if (got.atom_site !== want.atom_site)
                  flag_mismatch("atom_site", got.atom_site, want.atom_site);
               if (got.near_old !== want.near_old)
                  flag_mismatch("neighbors_before", got.near_old, want.near_old);
               if (got.near_new !== want.near_new)
                  flag_mismatch("neighbors_after", got.near_new, want.near_new);
            end
            result_seq++;
         end
         if (req_tvalid && req_tready) begin
            predict_outcome(req_tuser, req_tdata[REQ_ATOM_LSB +: ATOM_INDEX_W],
                            req_tdata[REQ_SITE_LSB +: SITE_FIELD_W],
                            req_tdata[REQ_DIR_LSB +: DIR_W],
                            req_tdata[REQ_RND_LSB +: RANDOM_BITS_DEF], want);
            awaited_outcomes.push_back(want);
         end
      end
      pending_results <= awaited_outcomes.size();
   end

endmodule

// File: tb/lattice_gas_hop_monte_carlo_tb.sv
module lattice_gas_hop_monte_carlo_tb;
   import lghmc_pkg::*;

   localparam int REQ_DATA_W = ((REQ_FIXED_W + RANDOM_BITS_DEF + 7) / 8) * 8;
   localparam int SITE_SPAN = 1 << SITE_FIELD_W;
   // A pool of adatoms that are placed on an empty lattice right after reset.
   // Half sit at the low end of the index range and half at the high end, so
   // every bit of atom_index toggles while only placed adatoms are ever read.
   localparam int POOL_SIZE = 16;
   localparam int POOL_HALF = POOL_SIZE / 2;
   localparam int POOL_HIGH_BASE = MAX_ADATOMS_DEF - POOL_HALF;
   localparam logic [DIR_W-1:0] DIR_MINUS_DIAG = 3'd5;
   localparam int DIR_TOP = (1 << DIR_W) - 1;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 40;
   localparam int RUN_LIMIT_CYCLES = 1_000_000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // Fields from bit 0: atom_index, site, direction, random_fraction, zero fill.
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   // Fields: op.
   logic                   req_tuser = OP_PLACE;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // Fields from bit 0: atom_site, neighbors_before, neighbors_after, zero fill.
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   // Fields: status.
   logic [STATUS_W-1:0]    rsp_tuser;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LATTICE_DIM_LOG2;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   int unsigned pending_results;
   int unsigned fail_count;

   // Idle chances in percent. The sender's is used only by the stimulus
   // process; the receiver's is read by the receiver process.
   int unsigned req_idle_pct = 28;
   int unsigned rsp_idle_pct = 86;

   // Long receiver hold: requested once by the stimulus, counted by the receiver.
   logic        long_hold_go = 1'b0;
   logic        long_hold_taken = 1'b0;
   int unsigned hold_left = 0;

   // Lattice settings the stimulus shapes its items around.
   int unsigned cur_lg = LG_RESET;
   int unsigned cur_count = COUNT_RESET;

   lattice_gas_hop_monte_carlo uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   hop_result_checker u_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .req_tuser       (req_tuser),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .pending_results (pending_results),
      .fail_count      (fail_count)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Hard stop in case the block hangs or drops a result.
   initial begin
      #(2 * RUN_LIMIT_CYCLES);
      $display("== FAIL ==");
      $finish;
   end

   // Result receiver. Apart from the single long hold, tready follows the
   // current idle chance. The long hold lets the block fill up: one result
   // parks in the output register, the next item is taken and finished, and
   // then req_tready has to fall while the sender keeps offering.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (long_hold_go && !long_hold_taken) begin
         long_hold_taken <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   function automatic logic [ATOM_INDEX_W-1:0] pool_atom(int unsigned slot);
      return ATOM_INDEX_W'(slot < POOL_HALF ? slot : POOL_HIGH_BASE + slot - POOL_HALF);
   endfunction

   // Starting sites on the 128 x 128 lattice. The low half forms a small
   // cluster so neighbor counts are nonzero; most of the high half sits on the
   // helical seam at both ends of the site range, the last two mid-lattice.
   function automatic logic [SITE_FIELD_W-1:0] home_of_slot(int unsigned slot);
      case (slot)
         0:  return 14'd200;
         1:  return 14'd201;
         2:  return 14'd202;
         3:  return 14'd328;
         4:  return 14'd329;
         5:  return 14'd330;
         6:  return 14'd456;
         7:  return 14'd457;
         8:  return 14'd0;
         9:  return 14'd16383;
         10: return 14'd1;
         11: return 14'd16382;
         12: return 14'd128;
         13: return 14'd16255;
         14: return 14'd5000;
         default: return 14'd5001;
      endcase
   endfunction

   // Any index at or above the adatom count is harmlessly invalid. Below the
   // count, only pool members are used so no unplaced adatom is ever read.
   function automatic logic [ATOM_INDEX_W-1:0] pick_atom();
      logic [ATOM_INDEX_W-1:0] a;
      if ($urandom_range(0, 99) < 85) a = pool_atom($urandom_range(0, POOL_SIZE - 1));
      else a = ATOM_INDEX_W'($urandom_range(0, MAX_ADATOMS_DEF - 1));
      if (a < cur_count && a >= POOL_HALF && a < POOL_HIGH_BASE)
         a = pool_atom($urandom_range(0, POOL_SIZE - 1));
      return a;
   endfunction

   // Place targets lean toward the low corner, where the cluster sits, with
   // some spread over the whole lattice and a few out-of-range sites.
   function automatic logic [SITE_FIELD_W-1:0] pick_place_site();
      int unsigned lg, nsites, roll;
      lg = (cur_lg < 1) ? 1 : cur_lg;
      nsites = 1 << (2 * lg);
      roll = $urandom_range(0, 99);
      if (roll < 50) return SITE_FIELD_W'($urandom_range(0, (nsites < 512 ? nsites : 512) - 1));
      if (roll < 85) return SITE_FIELD_W'($urandom_range(0, nsites - 1));
      return SITE_FIELD_W'($urandom_range(0, SITE_SPAN - 1));
   endfunction

   // Mostly uniform fractions, with some right at the acceptance thresholds
   // k/6 (one below, on, one above) and at both ends of the range.
   function automatic logic [RANDOM_BITS_DEF-1:0] pick_fraction();
      int unsigned roll, k, edge_val;
      roll = $urandom_range(0, 99);
      if (roll < 4) return '0;
      if (roll < 8) return '1;
      if (roll < 20) begin
         k = $urandom_range(1, 4);
         edge_val = (k << RANDOM_BITS_DEF) / 6;
         return RANDOM_BITS_DEF'(edge_val + $urandom_range(0, 2) - 1);
      end
      return RANDOM_BITS_DEF'($urandom_range(0, (1 << RANDOM_BITS_DEF) - 1));
   endfunction

   // Offers one item and returns at the edge where it is taken. The valid
   // stays high on return so that back-to-back items leave no gap.
   task automatic offer_item(input logic op, input logic [ATOM_INDEX_W-1:0] atom,
                             input logic [SITE_FIELD_W-1:0] site,
                             input logic [DIR_W-1:0] dir,
                             input logic [RANDOM_BITS_DEF-1:0] frac);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= REQ_DATA_W'({frac, dir, site, atom});
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic                       op;
      logic [SITE_FIELD_W-1:0]    site;
      logic [DIR_W-1:0]           dir;
      op = ($urandom_range(0, 99) < 70) ? OP_HOP : OP_PLACE;
      if (op == OP_PLACE) site = pick_place_site();
      else site = SITE_FIELD_W'($urandom_range(0, SITE_SPAN - 1));
      if ($urandom_range(0, 9) == 0) dir = DIR_W'($urandom_range(DIR_COUNT, DIR_TOP));
      else dir = DIR_W'($urandom_range(0, DIR_COUNT - 1));
      offer_item(op, pick_atom(), site, dir, pick_fraction());
   endtask

   // Drops valid and waits until every result has been taken. Every item
   // gives a result, so an empty scoreboard means the block is idle. The
   // first edge lets the count include an item taken at the current edge.
   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input int unsigned val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_W'(val);
      @(posedge clock);
   endtask

   // Only called while the block is idle.
   task automatic set_lattice(input int unsigned lg, input int unsigned count,
                              input int unsigned energy);
      write_csr(CSR_LATTICE_DIM_LOG2, lg);
      write_csr(CSR_ADATOM_COUNT, count);
      write_csr(CSR_INTERACTION_MODE, energy);
      csr_we <= 1'b0;
      cur_lg = lg;
      cur_count = count;
   endtask

   task automatic run_phase(input int unsigned lg, input int unsigned count,
                            input int unsigned energy, input int unsigned items,
                            input int unsigned sender_idle, input int unsigned receiver_idle,
                            input bit hold_midway, input bit pause_midway);
      wait_until_drained();
      set_lattice(lg, count, energy);
      req_idle_pct = sender_idle;
      rsp_idle_pct <= receiver_idle;
      for (int i = 0; i < items; i++) begin
         if (hold_midway && i == 10) long_hold_go <= 1'b1;
         if (pause_midway && i == items / 2) wait_until_drained();
         send_random_item();
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // The block clears its memories after reset and holds off requests meanwhile.
      while (!req_tready) @(posedge clock);

      // Full-size lattice, every index usable, every free hop accepted.
      set_lattice(MAX_DIM_LOG2_DEF, MAX_ADATOMS_DEF, MODE_FREE);
      for (int s = 0; s < POOL_SIZE; s++)
         offer_item(OP_PLACE, pool_atom(s), home_of_slot(s),
                    DIR_W'($urandom_range(0, DIR_TOP)), RANDOM_BITS_DEF'($urandom));

      // Place onto another adatom, onto its own site, and a re-place that
      // must free the old site.
      offer_item(OP_PLACE, pool_atom(0), 14'd201, DIR_PLUS_ONE, '0);
      offer_item(OP_PLACE, pool_atom(1), 14'd201, DIR_PLUS_ONE, '0);
      offer_item(OP_PLACE, pool_atom(15), 14'd8000, DIR_PLUS_ONE, '1);
      // All six directions, blocked and free targets, and both invalid codes.
      offer_item(OP_HOP, pool_atom(0), 14'd0, DIR_PLUS_ONE, '0);
      offer_item(OP_HOP, pool_atom(0), 14'd16383, DIR_MINUS_ONE, '0);
      offer_item(OP_HOP, pool_atom(2), 14'd0, DIR_PLUS_ROW, '1);
      offer_item(OP_HOP, pool_atom(2), 14'd0, DIR_MINUS_ROW, '1);
      offer_item(OP_HOP, pool_atom(2), 14'd0, DIR_PLUS_DIAG, '1);
      offer_item(OP_HOP, pool_atom(2), 14'd0, DIR_MINUS_DIAG, '1);
      offer_item(OP_HOP, pool_atom(0), 14'd0, DIR_COUNT, '0);
      offer_item(OP_HOP, pool_atom(0), 14'd0, DIR_W'(DIR_TOP), '0);
      // Hops across the helical seam between the last and the first site.
      offer_item(OP_HOP, pool_atom(8), 14'd0, DIR_MINUS_ONE, '0);
      offer_item(OP_HOP, pool_atom(9), 14'd0, DIR_PLUS_ONE, '0);
      offer_item(OP_HOP, pool_atom(9), 14'd0, DIR_PLUS_ROW, '0);

      // Energy rule inside the cluster with the most and least favorable draws.
      wait_until_drained();
      set_lattice(MAX_DIM_LOG2_DEF, MAX_ADATOMS_DEF, 3);
      offer_item(OP_HOP, pool_atom(3), 14'd0, DIR_MINUS_ONE, '1);
      offer_item(OP_HOP, pool_atom(7), 14'd0, DIR_PLUS_ONE, '1);
      offer_item(OP_HOP, pool_atom(4), 14'd0, DIR_MINUS_ROW, '0);
      offer_item(OP_HOP, pool_atom(5), 14'd0, DIR_PLUS_ONE, '1);

      // Out-of-range lattice size (clamped to the smallest), few adatoms:
      // bad indices, a site beyond the lattice, and hops from stale sites.
      wait_until_drained();
      set_lattice(0, 4, 1);
      offer_item(OP_PLACE, ATOM_INDEX_W'(9), 14'd1, DIR_PLUS_ONE, '0);
      offer_item(OP_PLACE, pool_atom(15), 14'd2, DIR_PLUS_ONE, '0);
      offer_item(OP_PLACE, pool_atom(0), 14'd16383, DIR_PLUS_ONE, '0);
      offer_item(OP_HOP, pool_atom(1), 14'd0, DIR_MINUS_ONE, '1);
      offer_item(OP_PLACE, pool_atom(0), 14'd3, DIR_PLUS_ONE, '0);
      offer_item(OP_HOP, pool_atom(0), 14'd0, DIR_PLUS_ROW, '0);

      // Random part. The first three phases idle the sender lightly and the
      // receiver heavily, the next three the other way round, the last three
      // not at all. Small lattices keep the adatoms crowded.
      run_phase(4, MAX_ADATOMS_DEF, 1, 110, 28, 86, 1'b0, 1'b0);
      run_phase(3, MAX_ADATOMS_DEF, 3, 110, 28, 86, 1'b0, 1'b0);
      run_phase(1, MAX_ADATOMS_DEF, 2, 70, 28, 86, 1'b0, 1'b0);
      run_phase(2, MAX_ADATOMS_DEF, 3, 110, 86, 28, 1'b1, 1'b0);
      run_phase(0, 4090, 1, 80, 86, 28, 1'b0, 1'b1);
      run_phase(MAX_DIM_LOG2_DEF, 1, 3, 60, 86, 28, 1'b0, 1'b0);
      run_phase(5, MAX_ADATOMS_DEF, 3, 110, 0, 0, 1'b0, 1'b0);
      run_phase(3, MAX_ADATOMS_DEF, 0, 110, 0, 0, 1'b0, 1'b0);
      run_phase(2, 2000, 3, 110, 0, 0, 1'b0, 1'b0);

      wait_until_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
